// File: rtl/core/sia_pkg.sv
package sia_pkg;

  // Field and register widths
  localparam int NUM_POINTS_W = 17;
  localparam int STEP_W       = 32;
  localparam int SAMPLE_W     = 32;
  localparam int RESULT_W     = 64;
  localparam int SUM_W        = 56;
  localparam int WEIGHT_W     = 6;
  localparam int PROD_W       = SAMPLE_W + WEIGHT_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 2'd1;

  localparam logic [NUM_POINTS_W-1:0] NUM_POINTS_RST = 17'd3;
  localparam logic [STEP_W-1:0]       STEP_SIZE_RST  = 32'd65536;
  localparam logic [NUM_POINTS_W-1:0] MAX_POINTS     = 17'd65536;

  // Scaling: divide by 24 * 2^16 = 3 * 2^19
  localparam int MAG_W      = SUM_W;
  localparam int MAG_LO_W   = 32;
  localparam int MAG_HI_W   = MAG_W - MAG_LO_W;
  localparam int FULL_W     = MAG_W + STEP_W;
  localparam int SCALE_SH   = 19;
  localparam int DIV_W      = FULL_W - SCALE_SH;
  localparam int DIV_CHUNK  = 8;
  localparam int DIV_STAGES = (DIV_W + DIV_CHUNK - 1) / DIV_CHUNK;
  localparam int DIV_PAD_W  = DIV_STAGES * DIV_CHUNK;

  // Result queue
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // Finished weighted sum handed to the scaler
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } sia_sum_t;

  // Sign and rounding flags that ride along the divider
  typedef struct packed {
    logic neg;
    logic inexact;
  } sia_side_t;

endpackage

// File: rtl/core/sia_sample_if.sv
interface sia_sample_if import sia_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// File: rtl/core/sia_result_if.sv
interface sia_result_if import sia_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] integral;

  modport source (output valid, output integral, input ready);
  modport sink (input valid, input integral, output ready);
endinterface

// File: rtl/core/sia_front.sv
module sia_front import sia_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [NUM_POINTS_W-1:0] num_points_i,
  input  logic                    credit_ok_i,
  sia_sample_if.sink              sample_ch,
  output logic                    last_accept_o,
  output sia_sum_t                sum_o
);

  logic [NUM_POINTS_W-1:0] idx_q, idx_d;
  logic [NUM_POINTS_W-1:0] n_eff, nm1, pos, tail, j;
  logic                    is_last, accept;
  logic [WEIGHT_W-1:0]     weight;

  logic                       a_valid_q, a_last_q;
  logic signed [SAMPLE_W-1:0] a_sample_q;
  logic [WEIGHT_W-1:0]        a_weight_q;

  logic                     p_valid_q, p_last_q;
  logic signed [PROD_W-1:0] p_prod_q, p_prod_d;
  logic signed [PROD_W-1:0] s_ext, w_ext;

  logic [SUM_W-1:0] sum_q, sum_next;
  sia_sum_t         sum_out_q;

  // Effective point count and position of the next request
  always_comb begin
    if (num_points_i < 17'd2) begin
      n_eff = 17'd2;
    end else if (num_points_i > MAX_POINTS) begin
      n_eff = MAX_POINTS;
    end else begin
      n_eff = num_points_i;
    end
    nm1     = n_eff - 17'd1;
    is_last = (idx_q >= nm1);
    pos     = is_last ? nm1 : idx_q;
    tail    = nm1 - pos;
    j       = (pos < tail) ? pos : tail;
  end

  // Weight numerator over 24
  always_comb begin
    if (n_eff[0]) begin
      if (pos == '0 || pos == nm1) begin
        weight = 6'd8;
      end else begin
        weight = pos[0] ? 6'd32 : 6'd16;
      end
    end else if (n_eff == 17'd2) begin
      weight = 6'd12;
    end else if (n_eff == 17'd4) begin
      weight = (pos == '0 || pos == 17'd3) ? 6'd9 : 6'd27;
    end else if (j == '0) begin
      weight = 6'd9;
    end else if (j == 17'd1) begin
      weight = 6'd28;
    end else if (j == 17'd2) begin
      weight = 6'd23;
    end else begin
      weight = 6'd24;
    end
  end

  // Hold off only the closing request while the result queue has no room
  assign sample_ch.ready = !is_last || credit_ok_i;
  assign accept          = sample_ch.valid && sample_ch.ready;
  assign last_accept_o   = accept && is_last;
  assign idx_d           = is_last ? '0 : idx_q + 17'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (accept) begin
      idx_q <= idx_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_last_q   <= is_last;
      a_sample_q <= sample_ch.sample;
      a_weight_q <= weight;
    end
  end

  // Weight times sample
  assign s_ext    = {{WEIGHT_W{a_sample_q[SAMPLE_W-1]}}, a_sample_q};
  assign w_ext    = {{SAMPLE_W{1'b0}}, a_weight_q};
  assign p_prod_d = s_ext * w_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      p_last_q <= a_last_q;
      p_prod_q <= p_prod_d;
    end
  end

  // Accumulate, wrapping at the sum width
  assign sum_next = sum_q + {{(SUM_W-PROD_W){p_prod_q[PROD_W-1]}}, p_prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      sum_out_q <= '0;
    end else begin
      sum_out_q.valid <= p_valid_q && p_last_q;
      if (p_valid_q) begin
        sum_q <= p_last_q ? '0 : sum_next;
      end
      if (p_valid_q && p_last_q) begin
        sum_out_q.sum <= sum_next;
      end
    end
  end

  assign sum_o = sum_out_q;

endmodule

// File: rtl/core/sia_div3.sv
module sia_div3 import sia_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  sia_side_t        side_i,
  output logic             out_valid_o,
  output logic [DIV_W-1:0] quot_o,
  output sia_side_t        side_o
);

  logic                 vld_q  [DIV_STAGES];
  logic [DIV_PAD_W-1:0] val_q  [DIV_STAGES];
  logic [DIV_PAD_W-1:0] val_d  [DIV_STAGES];
  logic [1:0]           rem_q  [DIV_STAGES];
  logic [1:0]           rem_d  [DIV_STAGES];
  sia_side_t            side_q [DIV_STAGES];

  // One chunk of long division by three, most significant bit first
  function automatic logic [DIV_CHUNK+1:0] div3_chunk(input logic [1:0] rem,
                                                      input logic [DIV_CHUNK-1:0] d);
    logic [2:0]           r;
    logic [DIV_CHUNK-1:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int b = DIV_CHUNK - 1; b >= 0; b--) begin
      r = {r[1:0], d[b]};
      if (r >= 3'd3) begin
        q[b] = 1'b1;
        r    = r - 3'd3;
      end
    end
    return {r[1:0], q};
  endfunction

  // Each stage replaces its chunk with quotient bits
  always_comb begin
    logic [DIV_PAD_W-1:0] src;
    logic [1:0]           src_rem;
    logic [DIV_CHUNK+1:0] res;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        src     = {{(DIV_PAD_W-DIV_W){1'b0}}, dividend_i};
        src_rem = 2'd0;
      end else begin
        src     = val_q[k-1];
        src_rem = rem_q[k-1];
      end
      res      = div3_chunk(src_rem, src[DIV_PAD_W-1-DIV_CHUNK*k -: DIV_CHUNK]);
      val_d[k] = src;
      val_d[k][DIV_PAD_W-1-DIV_CHUNK*k -: DIV_CHUNK] = res[DIV_CHUNK-1:0];
      rem_d[k] = res[DIV_CHUNK+1:DIV_CHUNK];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < DIV_STAGES; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q[0]  <= val_d[0];
    rem_q[0]  <= rem_d[0];
    side_q[0] <= side_i;
    for (int k = 1; k < DIV_STAGES; k++) begin
      val_q[k]  <= val_d[k];
      rem_q[k]  <= rem_d[k];
      side_q[k] <= side_q[k-1];
    end
  end

  // A non-zero remainder makes the quotient inexact
  assign out_valid_o    = vld_q[DIV_STAGES-1];
  assign quot_o         = val_q[DIV_STAGES-1][DIV_W-1:0];
  assign side_o.neg     = side_q[DIV_STAGES-1].neg;
  assign side_o.inexact = side_q[DIV_STAGES-1].inexact || (rem_q[DIV_STAGES-1] != 2'd0);

endmodule

// File: rtl/core/sia_scale.sv
module sia_scale import sia_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [STEP_W-1:0]   step_i,
  input  sia_sum_t            sum_i,
  output logic                res_valid_o,
  output logic [RESULT_W-1:0] res_o
);

  localparam logic [RESULT_W-1:0] RES_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
  localparam logic [RESULT_W-1:0] RES_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

  logic                s1_valid_q, s1_neg_q;
  logic [MAG_W-1:0]    s1_mag_q;
  logic                s2_valid_q, s2_neg_q;
  logic [MAG_HI_W-1:0] s2_hi_q;
  logic [MAG_LO_W+STEP_W-1:0] s2_a_q;
  logic                s3_valid_q, s3_neg_q;
  logic [MAG_LO_W+STEP_W-1:0] s3_a_q;
  logic [MAG_HI_W+STEP_W-1:0] s3_b_q;
  logic                s4_valid_q;
  logic [DIV_W-1:0]    s4_sh_q;
  sia_side_t           s4_side_q;
  logic [FULL_W-1:0]   full_prod;

  logic             dv_valid;
  logic [DIV_W-1:0] dv_quot;
  sia_side_t        dv_side;

  logic             f1_valid_q, f1_neg_q;
  logic [DIV_W-1:0] f1_q_q;
  logic             f2_valid_q;
  logic [RESULT_W-1:0] f2_res_q, f2_res_d;

  // Valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= sum_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      f1_valid_q <= dv_valid;
      f2_valid_q <= f1_valid_q;
    end
  end

  // Sign and magnitude, then the product in two partial products
  assign full_prod = {{(FULL_W-MAG_LO_W-STEP_W){1'b0}}, s3_a_q}
                   + {s3_b_q, {MAG_LO_W{1'b0}}};

  always_ff @(posedge clk_i) begin
    s1_neg_q <= sum_i.sum[SUM_W-1];
    s1_mag_q <= sum_i.sum[SUM_W-1] ? (~sum_i.sum + 1'b1) : sum_i.sum;

    s2_neg_q <= s1_neg_q;
    s2_hi_q  <= s1_mag_q[MAG_W-1:MAG_LO_W];
    s2_a_q   <= {{STEP_W{1'b0}}, s1_mag_q[MAG_LO_W-1:0]} * {{MAG_LO_W{1'b0}}, step_i};

    s3_neg_q <= s2_neg_q;
    s3_a_q   <= s2_a_q;
    s3_b_q   <= {{STEP_W{1'b0}}, s2_hi_q} * {{MAG_HI_W{1'b0}}, step_i};

    s4_sh_q           <= full_prod[FULL_W-1:SCALE_SH];
    s4_side_q.neg     <= s3_neg_q;
    s4_side_q.inexact <= (full_prod[SCALE_SH-1:0] != '0);
  end

  // Divide by three
  sia_div3 u_div3 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s4_valid_q),
    .dividend_i  (s4_sh_q),
    .side_i      (s4_side_q),
    .out_valid_o (dv_valid),
    .quot_o      (dv_quot),
    .side_o      (dv_side)
  );

  // Floor of a negative value rounds the magnitude up
  always_ff @(posedge clk_i) begin
    f1_neg_q <= dv_side.neg;
    f1_q_q   <= (dv_side.neg && dv_side.inexact) ? dv_quot + 1'b1 : dv_quot;
  end

  // Saturate and restore the sign
  always_comb begin
    if (f1_q_q[DIV_W-1:RESULT_W-1] != '0) begin
      f2_res_d = f1_neg_q ? RES_MIN : RES_MAX;
    end else if (f1_neg_q) begin
      f2_res_d = ~f1_q_q[RESULT_W-1:0] + 1'b1;
    end else begin
      f2_res_d = f1_q_q[RESULT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    f2_res_q <= f2_res_d;
  end

  assign res_valid_o = f2_valid_q;
  assign res_o       = f2_res_q;

endmodule

// File: rtl/core/sia_res_fifo.sv
module sia_res_fifo import sia_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [RESULT_W-1:0] data_i,
  sia_result_if.source        result_ch
);

  logic [RESULT_W-1:0]   mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  pop;

  assign result_ch.valid    = (cnt_q != '0);
  assign result_ch.integral = mem_q[rptr_q];
  assign pop                = result_ch.valid && result_ch.ready;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("result queue written while full");

  a_pop_moves_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> (cnt_q == $past(cnt_q) - 1'b1) && (rptr_q == $past(rptr_q) + 1'b1))
    else $error("result queue head did not advance");

  a_push_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> result_ch.valid)
    else $error("pushed result not presented");

endmodule

// File: rtl/core/sampled_integral_accumulator.sv
// Throughput: one sample request per cycle; the multiply-accumulate, the
// two-part step multiply and the nine-stage divide-by-three are all pipelined.
// The closing request of a run waits only while 16 results are in flight or queued.
// Reset (rst_ni low, asynchronous): sum and index cleared, queue emptied,
// num_points = 3, step_size = 1.0.
module sampled_integral_accumulator import sia_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sia_sample_if.sink            sample_ch_i,
  sia_result_if.source          result_ch_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [NUM_POINTS_W-1:0] num_points_q;
  logic [STEP_W-1:0]       step_size_q;
  logic [FIFO_CNT_W-1:0]   credits_q;
  logic                    credit_ok, last_accept, out_accept;
  sia_sum_t                sum;
  logic                    res_valid;
  logic [RESULT_W-1:0]     res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= NUM_POINTS_RST;
      step_size_q  <= STEP_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_POINTS: num_points_q <= cfg_data_i[NUM_POINTS_W-1:0];
        CFG_STEP_SIZE:  step_size_q  <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Results owed: taken at the closing request, returned at delivery
  assign out_accept = result_ch_o.valid && result_ch_o.ready;
  assign credit_ok  = (credits_q < FIFO_CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credits_q <= '0;
    end else if (last_accept && !out_accept) begin
      credits_q <= credits_q + 1'b1;
    end else if (out_accept && !last_accept) begin
      credits_q <= credits_q - 1'b1;
    end
  end

  sia_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .num_points_i  (num_points_q),
    .credit_ok_i   (credit_ok),
    .sample_ch     (sample_ch_i),
    .last_accept_o (last_accept),
    .sum_o         (sum)
  );

  sia_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step_size_q),
    .sum_i       (sum),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sia_res_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (res_valid),
    .data_i    (res),
    .result_ch (result_ch_o)
  );

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credits_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("more results owed than queue slots");

  a_valid_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_ch_o.valid |-> (credits_q != '0))
    else $error("result presented that no run owes");

  a_sum_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum.valid |=> !sum.valid)
    else $error("two runs closed in consecutive cycles");

endmodule
